// ===== rtl/core/bbf_pkg.sv =====
`default_nettype none
package bbf_pkg;
    localparam int unsigned OP_W     = 2;
    localparam int unsigned HASH_W   = 64;
    localparam int unsigned POS_W    = 9;
    localparam int unsigned WORD_W   = 64;
    localparam int unsigned WSEL_W   = 3;
    localparam int unsigned BIT_W    = 6;
    localparam int unsigned CNT_W    = 10;
    localparam int unsigned LG_W     = 4;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DAT_W = 10;

    typedef enum logic [OP_W-1:0] {
        OP_ADD   = 2'd0,
        OP_TEST  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LOG2 = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HASH_COUNT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_WAIT,
        ST_BITS,
        ST_WRITE,
        ST_CLEAR,
        ST_DONE
    } t_state;

    // classified job handed from front to back
    typedef struct packed {
        t_op               op;
        logic [19:0]       block;
        logic [POS_W-1:0]  start;
        logic [POS_W-1:0]  step;
        logic [CNT_W:0]    count;
    } t_job;
endpackage
`default_nettype wire

// ===== rtl/core/bbf_in_if.sv =====
`default_nettype none
interface bbf_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [63:0] hash_one;
    logic [63:0] hash_two;
    modport source (output valid, op, hash_one, hash_two, input ready);
    modport sink   (input valid, op, hash_one, hash_two, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/bbf_out_if.sv =====
`default_nettype none
interface bbf_out_if;
    logic       valid;
    logic       ready;
    logic       maybe_present;
    logic [1:0] done_op;
    modport source (output valid, maybe_present, done_op, input ready);
    modport sink   (input valid, maybe_present, done_op, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/bbf_front.sv =====
`default_nettype none
module bbf_front #(
    parameter int unsigned MAX_BLOCKS_LOG2 = 10
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    bbf_in_if.sink            in_ch,
    input  wire logic [3:0]   i_block_log2,
    input  wire logic [9:0]   i_hash_count,
    output bbf_pkg::t_job     o_job,
    output logic              o_job_valid,
    input  wire logic         i_job_pop
);
    import bbf_pkg::*;

    // two-entry queue
    t_job        r_q [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    t_job        w_job;
    logic [4:0]  w_lg;
    logic [19:0] w_mask;
    logic        w_push;

    always_comb begin
        w_lg = ({1'b0, i_block_log2} > 5'(MAX_BLOCKS_LOG2)) ? 5'(MAX_BLOCKS_LOG2)
                                                             : {1'b0, i_block_log2};
        w_mask = (20'd1 << w_lg) - 20'd1;
        w_job.op    = t_op'(in_ch.op);
        w_job.block = in_ch.hash_one[19:0] & w_mask;
        w_job.start = in_ch.hash_two[8:0];
        w_job.step  = in_ch.hash_two[40:32] | 9'd1;
        w_job.count = (i_hash_count > 10'd512) ? 11'd512 : {1'b0, i_hash_count};
    end

    assign in_ch.ready = (r_cnt != 2'd2);
    assign w_push      = in_ch.valid && in_ch.ready;
    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= w_job;
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (i_job_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_job_pop);
        end
    end

`ifndef SYNTHESIS
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_job_pop |-> o_job_valid) else $error("pop from empty queue");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count overflow");
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> !in_ch.ready) else $error("accept while full");
`endif
endmodule
`default_nettype wire

// ===== rtl/core/bbf_back.sv =====
`default_nettype none
module bbf_back #(
    parameter int unsigned MAX_BLOCKS_LOG2 = 10
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  bbf_pkg::t_job   i_job,
    input  wire logic       i_job_valid,
    output logic            o_job_pop,
    bbf_out_if.source       out_ch
);
    import bbf_pkg::*;

    localparam int unsigned ADDR_W = MAX_BLOCKS_LOG2 + WSEL_W;
    localparam int unsigned DEPTH  = 1 << ADDR_W;

    logic [WORD_W-1:0] r_mem [DEPTH];

    t_state r_state, n_state;
    t_job   r_job;
    logic [WSEL_W-1:0] r_wsel;
    logic [POS_W-1:0]  r_pos;
    logic [CNT_W:0]    r_left;
    logic [WORD_W-1:0] r_word, r_rd;
    logic              r_hit, r_dirty;
    logic [ADDR_W-1:0] r_clr;
    logic              r_ovalid, r_opres;
    logic [OP_W-1:0]   r_oop;

    logic [ADDR_W-1:0] w_addr;
    logic [ADDR_W-1:0] w_waddr;
    logic [WORD_W-1:0] w_wdata;
    logic              w_we;
    logic [POS_W-1:0]  w_npos;
    logic              w_inword, w_bit;

    // Each word of the block is read, then every position is walked one
    // per cycle; positions falling in this word update or test it.
    // The block index is already masked below 2^MAX_BLOCKS_LOG2.
    assign w_addr   = ADDR_W'({r_job.block, r_wsel});
    assign w_npos   = r_pos + r_job.step;
    assign w_inword = (r_pos[POS_W-1:BIT_W] == r_wsel);
    assign w_bit    = r_word[r_pos[BIT_W-1:0]];
    assign o_job_pop = (r_state == ST_IDLE) && i_job_valid && !r_ovalid;

    assign w_we    = (r_state == ST_WRITE && r_dirty) || (r_state == ST_CLEAR);
    assign w_waddr = (r_state == ST_CLEAR) ? r_clr : w_addr;
    assign w_wdata = (r_state == ST_CLEAR) ? '0 : r_word;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (o_job_pop) begin
                if (i_job.op == OP_CLEAR) n_state = ST_CLEAR;
                else if ((i_job.op == OP_ADD || i_job.op == OP_TEST)
                         && i_job.count != '0) n_state = ST_READ;
                else n_state = ST_DONE;
            end
            ST_READ:  n_state = ST_WAIT;
            ST_WAIT:  n_state = ST_BITS;
            ST_BITS:  if (r_left == 11'd1) n_state = ST_WRITE;
            ST_WRITE: n_state = (r_wsel == 3'd7) ? ST_DONE : ST_READ;
            // the sweep after reset gives no result item
            ST_CLEAR: if (r_clr == '1) n_state = (r_job.op == OP_CLEAR) ? ST_DONE : ST_IDLE;
            ST_DONE:  n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[w_addr];
        if (w_we) r_mem[w_waddr] <= w_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
            r_job.op <= OP_NONE;
        end else begin
            r_state  <= n_state;
            r_ovalid <= (r_state == ST_DONE) || (r_ovalid && !out_ch.ready);
            case (r_state)
                ST_IDLE: if (o_job_pop) begin
                    r_job <= i_job; r_wsel <= '0; r_hit <= 1'b1; r_clr <= '0;
                end
                ST_READ: begin
                    r_pos <= r_job.start; r_left <= r_job.count; r_dirty <= 1'b0;
                end
                ST_WAIT: r_word <= r_rd;
                ST_BITS: begin
                    if (w_inword) begin
                        if (r_job.op == OP_ADD) begin
                            r_word[r_pos[BIT_W-1:0]] <= 1'b1; r_dirty <= 1'b1;
                        end else if (!w_bit) r_hit <= 1'b0;
                    end
                    r_pos  <= w_npos;
                    r_left <= r_left - 11'd1;
                end
                ST_WRITE: r_wsel <= r_wsel + 3'd1;
                ST_CLEAR: r_clr <= r_clr + ADDR_W'(1);
                ST_DONE: begin
                    r_oop    <= r_job.op;
                    r_opres  <= (r_job.op == OP_TEST) && r_hit;
                end
                default: ;
            endcase
        end
    end

    assign out_ch.valid         = r_ovalid;
    assign out_ch.maybe_present = r_opres;
    assign out_ch.done_op       = r_oop;

`ifndef SYNTHESIS
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_pop |-> (r_state == ST_IDLE)) else $error("pop while busy");
    a_done_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) |=> r_ovalid) else $error("result lost");
    a_no_pop_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_pop |-> !r_ovalid) else $error("pop with result pending");
`endif
endmodule
`default_nettype wire

// ===== rtl/core/blocked_bloom_filter_core.sv =====
// Operation: add/test walk k = hash_count (capped at 512) positions over each of the 8 words
//   of the block (none if k is 0); clear sweeps all 8*2^MAX_BLOCKS_LOG2 words one a cycle.
// Throughput: one item at a time in the back end, which takes the next item only once
//   the result is taken; a two-entry queue lets the front accept while the back works.
// Reset (synchronous, active low) clears registers to defaults and then sweeps
//   the store, all 8*2^MAX_BLOCKS_LOG2 words, before the first item is processed.
`default_nettype none
module blocked_bloom_filter_core #(
    parameter int unsigned MAX_BLOCKS_LOG2 = 10
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    bbf_in_if.sink           in_ch,
    bbf_out_if.source        out_ch,
    input  wire logic        i_cfg_we,
    input  wire logic [0:0]  i_cfg_idx,
    input  wire logic [9:0]  i_cfg_data
);
    import bbf_pkg::*;

    logic [LG_W-1:0]  r_block_log2;
    logic [CNT_W-1:0] r_hash_count;
    t_job             w_job;
    logic             w_job_valid, w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_log2 <= '0;
            r_hash_count <= 10'd4;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_BLOCK_LOG2: r_block_log2 <= i_cfg_data[LG_W-1:0];
                REG_HASH_COUNT: r_hash_count <= i_cfg_data;
                default: ;
            endcase
        end
    end

    bbf_front #(.MAX_BLOCKS_LOG2(MAX_BLOCKS_LOG2)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(in_ch),
        .i_block_log2(r_block_log2), .i_hash_count(r_hash_count),
        .o_job(w_job), .o_job_valid(w_job_valid), .i_job_pop(w_pop)
    );

    bbf_back #(.MAX_BLOCKS_LOG2(MAX_BLOCKS_LOG2)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_job(w_job),
        .i_job_valid(w_job_valid), .o_job_pop(w_pop), .out_ch(out_ch)
    );
endmodule
`default_nettype wire
